// ----- hdl/lec_pkg.sv -----
package lec_pkg;

  localparam int unsigned POS_W  = 6;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_MIN = 8'h20;

  typedef enum logic [2:0] {
    CMD_CHAR   = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_RIGHT  = 3'd2,
    CMD_TOGGLE = 3'd3,
    CMD_HOME   = 3'd4,
    CMD_END    = 3'd5,
    CMD_BKSP   = 3'd6,
    CMD_ENTER  = 3'd7
  } lec_cmd_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REPLACE,
    OP_DELETE,
    OP_DRAIN
  } lec_op_e;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } lec_state_e;

  // broadcast from the controller to every cell of the row
  typedef struct packed {
    lec_op_e            op;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   len;
    logic [CHAR_W-1:0]  ch;
  } lec_ctrl_t;

endpackage

// ----- hdl/lec_cell.sv -----
module lec_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                  clk_i,
  input  lec_pkg::lec_ctrl_t    ctrl_i,
  input  logic [7:0]            left_i,
  input  logic [7:0]            right_i,
  output logic [7:0]            char_o
);
  import lec_pkg::*;

  localparam logic [7:0] IdxC = 8'(IDX);

  logic [CHAR_W-1:0] char_q, char_d;
  logic [7:0]        pos_x, len_x;

  assign pos_x = {2'b00, ctrl_i.pos};
  assign len_x = {2'b00, ctrl_i.len};

  always_comb begin
    char_d = char_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (IdxC == pos_x) begin
          char_d = ctrl_i.ch;
        end else if (IdxC > pos_x && IdxC <= len_x) begin
          char_d = left_i;
        end
      end
      OP_REPLACE: begin
        if (IdxC == pos_x) char_d = ctrl_i.ch;
      end
      // pos is the removed slot, len the new length
      OP_DELETE: begin
        if (IdxC >= pos_x && IdxC < len_x) char_d = right_i;
      end
      OP_DRAIN: char_d = right_i;
      default:  char_d = char_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;

endmodule

// ----- hdl/line_edit_buffer.sv -----
// Single-line keystroke editor. Each key beat on the slave side (tuser = command,
// tdata = character) produces exactly one status beat on the master side, marked
// with tlast, carrying cursor, length and mode after the key. Printable
// characters (0x20 and up) are inserted at the cursor (tail moves right, ignored
// when the line is at min(capacity, LINE_DEPTH)) or, in replace mode, overwrite
// the character under the cursor or append at the end. Backspace closes the gap.
// Enter first sends the stored line as character beats (tuser bit 0 set, cursor,
// length and mode reported as zero), then the status beat, and clears the line
// and the mode. The line lives in a row of LINE_DEPTH character cells; insert,
// backspace and each enter output step move the affected cells to their neighbors
// together, and replace writes one cell. An editing key's status beat is loaded
// into the output register on acceptance; on enter the row shifts one cell toward
// the output per character sent, waiting while the output is held. The next key
// is taken once the previous key's last beat is loaded and the output register is
// free or being read. Capacity, written via cfg_we_i / cfg_wdata_i, resets to 63.
module line_edit_buffer #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [5:0]               cfg_wdata_i,    // capacity
  // key beats
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] key_char
  input  logic [2:0]               s_axis_tuser,   // [2:0] cmd
  // status and character beats
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [7:0] out_char, [13:8] cursor_pos,
                                                   // [19:14] line_len, [20] replace_on,
                                                   // [23:21] zero
  output logic [0:0]               m_axis_tuser,   // [0] is_char
  output logic                     m_axis_tlast
);
  import lec_pkg::*;

  // largest length the row can ever hold
  localparam int unsigned LimMax  = (LINE_DEPTH < 63) ? LINE_DEPTH : 63;
  localparam logic [POS_W-1:0] LimMaxC = POS_W'(LimMax);

  lec_state_e        state_q, state_d;
  logic [POS_W-1:0]  cnt_q, cnt_d;        // characters still to send on enter
  logic [POS_W-1:0]  cursor_q, cursor_d;
  logic [POS_W-1:0]  length_q, length_d;
  logic              replace_q, replace_d;
  logic [5:0]        cap_q;
  logic [POS_W-1:0]  lim;

  // output register
  logic              out_vld_q, out_vld_d;
  logic              out_isc_q, out_isc_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [POS_W-1:0]  out_cur_q, out_cur_d;
  logic [POS_W-1:0]  out_len_q, out_len_d;
  logic              out_rep_q, out_rep_d;
  logic              out_last_q, out_last_d;

  logic              slot_free;
  logic              key_acc;
  lec_cmd_e          cmd;
  logic [CHAR_W-1:0] key_char;
  lec_ctrl_t         ctrl;

  logic [CHAR_W-1:0] chars [LINE_DEPTH];

  assign lim       = (cap_q < LimMaxC) ? cap_q : LimMaxC;
  assign slot_free = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
  assign key_acc   = s_axis_tvalid && s_axis_tready;
  assign cmd       = lec_cmd_e'(s_axis_tuser);
  assign key_char  = s_axis_tdata;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (key_acc && cmd == CMD_ENTER) begin
          state_d = ST_DRAIN;
          cnt_d   = length_q;
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // edit decisions, cell control and output beat
  always_comb begin
    cursor_d   = cursor_q;
    length_d   = length_q;
    replace_d  = replace_q;
    ctrl.op    = OP_HOLD;
    ctrl.pos   = cursor_q;
    ctrl.len   = length_q;
    ctrl.ch    = key_char;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_isc_d  = out_isc_q;
    out_char_d = out_char_q;
    out_cur_d  = out_cur_q;
    out_len_d  = out_len_q;
    out_rep_d  = out_rep_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (key_acc) begin
          unique case (cmd)
            CMD_CHAR: begin
              if (key_char >= CHAR_MIN) begin
                if (!replace_q) begin
                  if (length_q < lim) begin
                    ctrl.op  = OP_INSERT;
                    cursor_d = cursor_q + 1'b1;
                    length_d = length_q + 1'b1;
                  end
                end else if (cursor_q < length_q) begin
                  ctrl.op  = OP_REPLACE;
                  cursor_d = cursor_q + 1'b1;
                end else if (length_q < lim) begin
                  // append at the end of the line
                  ctrl.op  = OP_REPLACE;
                  cursor_d = cursor_q + 1'b1;
                  length_d = length_q + 1'b1;
                end
              end
            end
            CMD_LEFT:   if (cursor_q != '0) cursor_d = cursor_q - 1'b1;
            CMD_RIGHT:  if (cursor_q < length_q) cursor_d = cursor_q + 1'b1;
            CMD_TOGGLE: replace_d = !replace_q;
            CMD_HOME:   cursor_d = '0;
            CMD_END:    cursor_d = length_q;
            CMD_BKSP: begin
              if (length_q != '0 && cursor_q != '0) begin
                ctrl.op  = OP_DELETE;
                ctrl.pos = cursor_q - 1'b1;
                ctrl.len = length_q - 1'b1;
                cursor_d = cursor_q - 1'b1;
                length_d = length_q - 1'b1;
              end
            end
            CMD_ENTER: begin
              cursor_d  = '0;
              length_d  = '0;
              replace_d = 1'b0;
            end
            default: ;
          endcase

          // enter reports from the drain state instead
          if (cmd != CMD_ENTER) begin
            out_vld_d  = 1'b1;
            out_isc_d  = 1'b0;
            out_char_d = '0;
            out_cur_d  = cursor_d;
            out_len_d  = length_d;
            out_rep_d  = replace_d;
            out_last_d = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_cur_d  = '0;
          out_len_d  = '0;
          out_rep_d  = 1'b0;
          if (cnt_q != '0) begin
            // head cell goes out, row moves one step toward it
            ctrl.op    = OP_DRAIN;
            out_isc_d  = 1'b1;
            out_char_d = chars[0];
            out_last_d = 1'b0;
          end else begin
            out_isc_d  = 1'b0;
            out_char_d = '0;
            out_last_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cursor_q  <= '0;
      length_q  <= '0;
      replace_q <= 1'b0;
      cap_q     <= 6'd63;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cursor_q  <= cursor_d;
      length_q  <= length_d;
      replace_q <= replace_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_isc_q  <= out_isc_d;
    out_char_q <= out_char_d;
    out_cur_q  <= out_cur_d;
    out_len_q  <= out_len_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
  end

  // row of character cells
  for (genvar g = 0; g < LINE_DEPTH; g++) begin : g_row
    logic [CHAR_W-1:0] left_c, right_c;
    if (g == 0) begin : g_head
      assign left_c = '0;
    end else begin : g_mid_l
      assign left_c = chars[g-1];
    end
    if (g == LINE_DEPTH - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_mid_r
      assign right_c = chars[g+1];
    end
    lec_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_c),
      .right_i (right_c),
      .char_o  (chars[g])
    );
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_rep_q, out_len_q, out_cur_q, out_char_q};
  assign m_axis_tuser  = out_isc_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  // cursor never runs past the end of the line
  a_cursor_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= length_q)
    else $error("cursor beyond line length");

  // the line never outgrows the cell row
  a_length_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    length_q <= LimMaxC)
    else $error("line longer than the cell row");

  // while sending a line the edit state is already cleared
  a_drain_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (cursor_q == '0 && length_q == '0 && !replace_q))
    else $error("edit state not cleared during enter");

  // enter leads to the drain with the old length as the count
  a_enter_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_acc && cmd == CMD_ENTER) |=> (state_q == ST_DRAIN && cnt_q == $past(length_q)))
    else $error("enter did not start the line output");

  // character beats never carry tlast
  a_char_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_isc_q) |-> !out_last_q)
    else $error("character beat marked last");
`endif

endmodule
